### rtl/core/serial_command_line_heater_fan_control_assert.svh
// assertion macros for the serial command line heater and fan control block
// used by the port checker; no other dependencies
`ifndef SERIAL_COMMAND_LINE_HEATER_FAN_CONTROL_ASSERT_SVH
`define SERIAL_COMMAND_LINE_HEATER_FAN_CONTROL_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SCHFC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define SCHFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/schfc_pkg.sv
// shared constants, types and helper functions for the command line decoder
// no dependencies
`default_nettype none

package schfc_pkg;

  // line store geometry
  localparam int unsigned LINE_BYTES = 15;
  localparam int unsigned LB_AW      = $clog2(LINE_BYTES);
  localparam int unsigned LB_CW      = $clog2(LINE_BYTES + 1);

  // configuration port
  localparam int unsigned CFG_IW = 1;
  localparam int unsigned CFG_DW = 7;

  // special characters
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_DOT = 8'h2E;

  // command prefixes, left aligned in six characters
  localparam logic [47:0] PFX_READ  = {"READ", 16'h0000};
  localparam logic [47:0] PFX_CHAN  = {"CHAN;", 8'h00};
  localparam logic [47:0] PFX_DCFAN = "DCFAN;";
  localparam logic [47:0] PFX_OT1   = {"OT1;", 16'h0000};
  localparam logic [47:0] PFX_DISC  = "+DISC:";
  localparam int unsigned PLEN_READ  = 4;
  localparam int unsigned PLEN_CHAN  = 5;
  localparam int unsigned PLEN_DCFAN = 6;
  localparam int unsigned PLEN_OT1   = 4;
  localparam int unsigned PLEN_DISC  = 6;

  // line layout
  localparam int unsigned READ_LEN     = 4;
  localparam int unsigned CHAN_LEN     = 9;
  localparam int unsigned CHAN_FIRST   = 5;
  localparam int unsigned CHAN_LAST    = 8;
  localparam int unsigned PSTART_DCFAN = 6;
  localparam int unsigned PSTART_OT1   = 4;
  localparam int unsigned PARAM_DIGITS = 3;
  localparam int unsigned PARAM_MAX    = 100;

  // settings
  localparam logic [4:0] HEAT_MAX   = 5'd24;
  localparam logic [2:0] FAN_MAX    = 3'd6;
  localparam logic [4:0] HEAT_RESET = 5'd2;
  localparam logic [2:0] FAN_RESET  = 3'd1;
  localparam logic [6:0] CFG_HEAT_RESET = 7'd10;
  localparam logic [6:0] CFG_FAN_RESET  = 7'd50;

  // x / 100 as (x * 1311) >> 17, exact for x below 3200
  localparam logic [10:0] RECIP_100 = 11'd1311;

  typedef enum logic [2:0] {
    EV_READ  = 3'd0,
    EV_CHAN  = 3'd1,
    EV_FAN   = 3'd2,
    EV_HEAT  = 3'd3,
    EV_OTHER = 3'd4,
    EV_DISC  = 3'd5
  } ev_t;

  typedef enum logic [CFG_IW-1:0] {
    CFG_HEAT_PCT = 1'b0,
    CFG_FAN_PCT  = 1'b1
  } cfg_idx_t;

  // what a walk over the line store found
  typedef struct packed {
    logic             m_read;
    logic             m_chan;
    logic             m_dcfan;
    logic             m_ot1;
    logic             m_disc;
    logic [LB_CW-1:0] len;
    logic [31:0]      chan;
    logic [6:0]       fan_val;
    logic             fan_ok;
    logic [6:0]       heat_val;
    logic             heat_ok;
  } scan_res_t;

  // true when pos lies past the prefix or the byte matches it
  function automatic logic pfx_hit(input logic [47:0] s, input int unsigned plen,
                                   input logic [LB_AW-1:0] pos, input logic [7:0] b);
    logic [7:0] c;
    c = 8'h00;
    case (pos[2:0])
      3'd0:    c = s[47:40];
      3'd1:    c = s[39:32];
      3'd2:    c = s[31:24];
      3'd3:    c = s[23:16];
      3'd4:    c = s[15:8];
      3'd5:    c = s[7:0];
      default: c = 8'h00;
    endcase
    if (32'(pos) >= plen) begin
      pfx_hit = 1'b1;
    end else begin
      pfx_hit = (b == c);
    end
  endfunction

  // level = min(24, 24 * (pct + 2) / 100)
  function automatic logic [4:0] heat_step_of(input logic [6:0] pct);
    logic [7:0]  s;
    logic [11:0] x;
    logic [22:0] p;
    logic [5:0]  q;
    s = {1'b0, pct} + 8'd2;
    x = ({4'b0, s} << 4) + ({4'b0, s} << 3);
    p = {11'b0, x} * {12'b0, RECIP_100};
    q = p[22:17];
    heat_step_of = (q > {1'b0, HEAT_MAX}) ? HEAT_MAX : q[4:0];
  endfunction

  // step = min(6, 6 * (pct + 8) / 100)
  function automatic logic [2:0] fan_step_of(input logic [6:0] pct);
    logic [7:0]  s;
    logic [9:0]  x;
    logic [20:0] p;
    logic [3:0]  q;
    s = {1'b0, pct} + 8'd8;
    x = ({2'b0, s} << 2) + ({2'b0, s} << 1);
    p = {11'b0, x} * {10'b0, RECIP_100};
    q = p[20:17];
    fan_step_of = (q > {1'b0, FAN_MAX}) ? FAN_MAX : q[2:0];
  endfunction

  function automatic logic [23:0] heat_pattern(input logic [4:0] lvl);
    logic [23:0] v;
    case (lvl)
      5'd0:    v = 24'h000000;
      5'd1:    v = 24'h000001;
      5'd2:    v = 24'h001001;
      5'd3:    v = 24'h010101;
      5'd4:    v = 24'h041041;
      5'd5:    v = 24'h084211;
      5'd6:    v = 24'h111111;
      5'd7:    v = 24'h122449;
      5'd8:    v = 24'h249249;
      5'd9:    v = 24'h252525;
      5'd10:   v = 24'h295295;
      5'd11:   v = 24'h2AA555;
      5'd12:   v = 24'h555555;
      5'd13:   v = 24'h555AAB;
      5'd14:   v = 24'h56B56B;
      5'd15:   v = 24'h5B5B5B;
      5'd16:   v = 24'h6DB6DB;
      5'd17:   v = 24'h6DDBB7;
      5'd18:   v = 24'h777777;
      5'd19:   v = 24'h77BDEF;
      5'd20:   v = 24'h7DF7DF;
      5'd21:   v = 24'h7F7F7F;
      5'd22:   v = 24'h7FF7FF;
      5'd23:   v = 24'h7FFFFF;
      default: v = 24'hFFFFFF;
    endcase
    heat_pattern = v;
  endfunction

  function automatic logic [9:0] fan_duty(input logic [2:0] step);
    logic [9:0] v;
    case (step)
      3'd0:    v = 10'h000;
      3'd1:    v = 10'h0AB;
      3'd2:    v = 10'h155;
      3'd3:    v = 10'h200;
      3'd4:    v = 10'h2AB;
      3'd5:    v = 10'h355;
      default: v = 10'h3FF;
    endcase
    fan_duty = v;
  endfunction

endpackage

`default_nettype wire

### rtl/core/schfc_ram.sv
// generic single write port ram with one registered read port
// no dependencies
`default_nettype none

module schfc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### rtl/core/schfc_scan.sv
// line walker: prefix matches, line length, channel bytes and two parameter parsers
// depends on schfc_pkg
`default_nettype none

module schfc_scan import schfc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             dv,
  input  logic [LB_AW-1:0] idx,
  input  logic [7:0]       b,
  output scan_res_t        res
);

  logic             m_read_r, m_read_nxt;
  logic             m_chan_r, m_chan_nxt;
  logic             m_dcfan_r, m_dcfan_nxt;
  logic             m_ot1_r, m_ot1_nxt;
  logic             m_disc_r, m_disc_nxt;
  logic             zero_r, zero_nxt;
  logic [LB_CW-1:0] len_r, len_nxt;
  logic [31:0]      chan_r, chan_nxt;
  // parser 0 reads the fan parameter, parser 1 the heater parameter
  logic [7:0]       pr_r [2];
  logic [7:0]       pr_nxt [2];
  logic [1:0]       pn_r [2];
  logic [1:0]       pn_nxt [2];
  logic             pstop_r [2];
  logic             pstop_nxt [2];
  logic             pterm_r [2];
  logic             pterm_nxt [2];
  logic [LB_CW-1:0] pst [2];
  logic [LB_CW-1:0] idx_c;

  assign pst[0] = LB_CW'(PSTART_DCFAN);
  assign pst[1] = LB_CW'(PSTART_OT1);
  assign idx_c  = LB_CW'(idx);

  always_comb begin
    m_read_nxt  = m_read_r;
    m_chan_nxt  = m_chan_r;
    m_dcfan_nxt = m_dcfan_r;
    m_ot1_nxt   = m_ot1_r;
    m_disc_nxt  = m_disc_r;
    zero_nxt    = zero_r;
    len_nxt     = len_r;
    chan_nxt    = chan_r;
    for (int k = 0; k < 2; k++) begin
      pr_nxt[k]    = pr_r[k];
      pn_nxt[k]    = pn_r[k];
      pstop_nxt[k] = pstop_r[k];
      pterm_nxt[k] = pterm_r[k];
    end
    if (start) begin
      m_read_nxt  = 1'b1;
      m_chan_nxt  = 1'b1;
      m_dcfan_nxt = 1'b1;
      m_ot1_nxt   = 1'b1;
      m_disc_nxt  = 1'b1;
      zero_nxt    = 1'b0;
      len_nxt     = LB_CW'(LINE_BYTES);
      chan_nxt    = 32'h0;
      for (int k = 0; k < 2; k++) begin
        pr_nxt[k]    = 8'h00;
        pn_nxt[k]    = 2'd0;
        pstop_nxt[k] = 1'b0;
        pterm_nxt[k] = 1'b0;
      end
    end else if (dv) begin
      m_read_nxt  = m_read_r  & pfx_hit(PFX_READ,  PLEN_READ,  idx, b);
      m_chan_nxt  = m_chan_r  & pfx_hit(PFX_CHAN,  PLEN_CHAN,  idx, b);
      m_dcfan_nxt = m_dcfan_r & pfx_hit(PFX_DCFAN, PLEN_DCFAN, idx, b);
      m_ot1_nxt   = m_ot1_r   & pfx_hit(PFX_OT1,   PLEN_OT1,   idx, b);
      m_disc_nxt  = m_disc_r  & pfx_hit(PFX_DISC,  PLEN_DISC,  idx, b);
      // line ends at the first zero byte
      if (!zero_r && (b == CH_NUL)) begin
        zero_nxt = 1'b1;
        len_nxt  = idx_c;
      end
      if ((idx_c >= LB_CW'(CHAN_FIRST)) && (idx_c <= LB_CW'(CHAN_LAST))) begin
        chan_nxt = {chan_r[23:0], b};
      end
      for (int k = 0; k < 2; k++) begin
        if ((idx_c >= pst[k]) && !pstop_r[k]) begin
          if ((b == CH_NUL) || (b == CH_DOT)) begin
            pstop_nxt[k] = 1'b1;
            pterm_nxt[k] = 1'b1;
          end else if (pn_r[k] == 2'(PARAM_DIGITS)) begin
            pstop_nxt[k] = 1'b1;
            pterm_nxt[k] = 1'b0;
          end else begin
            // mod-256 decimal accumulate, 208 is -'0'
            pr_nxt[k] = (pr_r[k] << 3) + (pr_r[k] << 1) + b + 8'd208;
            pn_nxt[k] = pn_r[k] + 2'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_read_r  <= 1'b0;
      m_chan_r  <= 1'b0;
      m_dcfan_r <= 1'b0;
      m_ot1_r   <= 1'b0;
      m_disc_r  <= 1'b0;
      zero_r    <= 1'b0;
      for (int k = 0; k < 2; k++) begin
        pn_r[k]    <= 2'd0;
        pstop_r[k] <= 1'b0;
        pterm_r[k] <= 1'b0;
      end
    end else begin
      m_read_r  <= m_read_nxt;
      m_chan_r  <= m_chan_nxt;
      m_dcfan_r <= m_dcfan_nxt;
      m_ot1_r   <= m_ot1_nxt;
      m_disc_r  <= m_disc_nxt;
      zero_r    <= zero_nxt;
      for (int k = 0; k < 2; k++) begin
        pn_r[k]    <= pn_nxt[k];
        pstop_r[k] <= pstop_nxt[k];
        pterm_r[k] <= pterm_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    len_r  <= len_nxt;
    chan_r <= chan_nxt;
    for (int k = 0; k < 2; k++) begin
      pr_r[k] <= pr_nxt[k];
    end
  end

  always_comb begin
    res.m_read   = m_read_r;
    res.m_chan   = m_chan_r;
    res.m_dcfan  = m_dcfan_r;
    res.m_ot1    = m_ot1_r;
    res.m_disc   = m_disc_r;
    res.len      = len_r;
    res.chan     = chan_r;
    res.fan_val  = pr_r[0][6:0];
    res.fan_ok   = (!pstop_r[0] || pterm_r[0]) && (pr_r[0] <= 8'(PARAM_MAX));
    res.heat_val = pr_r[1][6:0];
    res.heat_ok  = (!pstop_r[1] || pterm_r[1]) && (pr_r[1] <= 8'(PARAM_MAX));
  end

endmodule

`default_nettype wire

### rtl/core/serial_command_line_heater_fan_control.sv
// top level of the serial command line decoder for heater and fan control
// depends on schfc_pkg, schfc_ram and schfc_scan
//
// Bytes arrive on the in_ channel, one per transfer. Plain bytes are written
// into a LINE_BYTES (15) entry line store held in a single-port-write,
// registered-read ram; the write position wraps. A plain byte leaves the
// block idle, with in_ready high for the next byte. LF stores a zero at the
// write position and CR stores nothing; both then walk the whole line store
// through the one read port, one byte per cycle, to classify the line
// (READ, CHAN;xxxx, DCFAN;n, OT1;n, other, or a +DISC: prefix for CR).
// in_ready then stays low through the read walk, the wait for the
// registered read data, the decide step that updates the settings
// (ST_FIN) and the result load (ST_POST), which waits for a free output
// slot. A CR that gives no result skips the load.
// An LF gives one result transfer on the out_ channel; a CR gives one
// only for a disconnect line. Results sit in an output register, so plain
// bytes keep flowing while a result waits for out_ready; a further line end
// waits in its load cycle for that slot. The line store resets to all zero
// through fifteen valid flops, cleared by reset. The cfg_ port writes the
// disconnect heater and fan percentages; write it only while the block is idle.
`default_nettype none

module serial_command_line_heater_fan_control import schfc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // byte input
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_rx_byte,
  // line results
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        out_event_res,
  output logic [6:0]        out_param_value,
  output logic              out_param_ok,
  output logic [31:0]       out_channel_text,
  output logic [4:0]        out_heater_level,
  output logic [23:0]       out_heater_pattern,
  output logic [9:0]        out_fan_duty,
  // configuration writes
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  typedef enum logic [1:0] {
    ST_IDLE,  // taking bytes
    ST_SCAN,  // walking the line store
    ST_FIN,   // classify and update settings
    ST_POST   // hand result to the output register
  } state_t;

  state_t            state_r, state_nxt;
  logic [LB_AW-1:0]  wp_r, wp_nxt;
  logic [LB_CW-1:0]  cnt_r, cnt_nxt;
  logic              is_cr_r, is_cr_nxt;
  logic [4:0]        heat_r, heat_nxt;
  logic [2:0]        fan_r, fan_nxt;
  logic [6:0]        cfg_heat_r, cfg_heat_nxt;
  logic [6:0]        cfg_fan_r, cfg_fan_nxt;
  logic [LINE_BYTES-1:0] vld_r, vld_nxt;
  logic              dv_r;
  logic              out_valid_r, out_valid_nxt;

  // pending result fields, held from decide until the output load
  ev_t               ev_r, ev_nxt;
  logic [6:0]        pval_r, pval_nxt;
  logic              pok_r, pok_nxt;
  logic [31:0]       chan_r, chan_nxt;

  logic [LB_AW-1:0]  didx_r;
  logic              rvld_r;
  logic [2:0]        out_ev_r;
  logic [6:0]        out_pval_r;
  logic              out_pok_r;
  logic [31:0]       out_chan_r;
  logic [4:0]        out_lvl_r;
  logic [23:0]       out_pat_r;
  logic [9:0]        out_duty_r;

  logic              acc;
  logic              is_cr;
  logic              is_lf;
  logic              ram_we;
  logic [7:0]        ram_wdata;
  logic              rd_en;
  logic [LB_AW-1:0]  raddr;
  logic [7:0]        ram_rdata;
  logic [7:0]        scan_b;
  logic              scan_start;
  logic              load;
  scan_res_t         sres;

  assign in_ready   = (state_r == ST_IDLE);
  assign acc        = in_valid && in_ready;
  assign is_cr      = (in_rx_byte == CH_CR);
  assign is_lf      = (in_rx_byte == CH_LF);
  // LF stores the terminating zero, CR stores nothing
  assign ram_we     = acc && !is_cr;
  assign ram_wdata  = is_lf ? CH_NUL : in_rx_byte;
  assign scan_start = acc && (is_cr || is_lf);
  assign rd_en      = (state_r == ST_SCAN) && (cnt_r != LB_CW'(LINE_BYTES));
  assign raddr      = cnt_r[LB_AW-1:0];
  // never-written entries read as zero
  assign scan_b     = rvld_r ? ram_rdata : CH_NUL;

  schfc_ram #(
    .WIDTH (8),
    .DEPTH (LINE_BYTES)
  ) u_line (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (ram_wdata),
    .re    (rd_en),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  schfc_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .start (scan_start),
    .dv    (dv_r),
    .idx   (didx_r),
    .b     (scan_b),
    .res   (sres)
  );

  always_comb begin
    state_nxt    = state_r;
    wp_nxt       = wp_r;
    cnt_nxt      = cnt_r;
    is_cr_nxt    = is_cr_r;
    heat_nxt     = heat_r;
    fan_nxt      = fan_r;
    cfg_heat_nxt = cfg_heat_r;
    cfg_fan_nxt  = cfg_fan_r;
    vld_nxt      = vld_r;
    ev_nxt       = ev_r;
    pval_nxt     = pval_r;
    pok_nxt      = pok_r;
    chan_nxt     = chan_r;
    load         = 1'b0;

    if (cfg_we) begin
      case (cfg_index)
        CFG_HEAT_PCT: cfg_heat_nxt = cfg_wdata;
        CFG_FAN_PCT:  cfg_fan_nxt  = cfg_wdata;
        default:      ;
      endcase
    end

    if (ram_we) begin
      vld_nxt[wp_r] = 1'b1;
    end

    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          if (scan_start) begin
            wp_nxt    = '0;
            cnt_nxt   = '0;
            is_cr_nxt = is_cr;
            state_nxt = ST_SCAN;
          end else if (wp_r == LB_AW'(LINE_BYTES - 1)) begin
            wp_nxt = '0;
          end else begin
            wp_nxt = wp_r + LB_AW'(1);
          end
        end
      end
      ST_SCAN: begin
        // last byte is consumed by the walker on the cycle the count tops out
        if (cnt_r == LB_CW'(LINE_BYTES)) begin
          state_nxt = ST_FIN;
        end else begin
          cnt_nxt = cnt_r + LB_CW'(1);
        end
      end
      ST_FIN: begin
        pval_nxt = '0;
        pok_nxt  = 1'b0;
        chan_nxt = '0;
        state_nxt = ST_POST;
        if (is_cr_r) begin
          if (sres.m_disc) begin
            ev_nxt   = EV_DISC;
            heat_nxt = heat_step_of(cfg_heat_r);
            fan_nxt  = fan_step_of(cfg_fan_r);
          end else begin
            // plain CR: no result
            state_nxt = ST_IDLE;
          end
        end else if (sres.m_read && (sres.len == LB_CW'(READ_LEN))) begin
          ev_nxt = EV_READ;
        end else if (sres.m_chan && (sres.len == LB_CW'(CHAN_LEN))) begin
          ev_nxt   = EV_CHAN;
          chan_nxt = sres.chan;
        end else if (sres.m_dcfan) begin
          ev_nxt = EV_FAN;
          if (sres.fan_ok) begin
            pval_nxt = sres.fan_val;
            pok_nxt  = 1'b1;
            fan_nxt  = fan_step_of(sres.fan_val);
          end
        end else if (sres.m_ot1) begin
          ev_nxt = EV_HEAT;
          if (sres.heat_ok) begin
            pval_nxt = sres.heat_val;
            pok_nxt  = 1'b1;
            heat_nxt = heat_step_of(sres.heat_val);
          end
        end else begin
          ev_nxt = EV_OTHER;
        end
      end
      ST_POST: begin
        // wait for a free output slot
        if (!out_valid_r || out_ready) begin
          load      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wp_r        <= '0;
      cnt_r       <= '0;
      is_cr_r     <= 1'b0;
      heat_r      <= HEAT_RESET;
      fan_r       <= FAN_RESET;
      cfg_heat_r  <= CFG_HEAT_RESET;
      cfg_fan_r   <= CFG_FAN_RESET;
      vld_r       <= '0;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      cnt_r       <= cnt_nxt;
      is_cr_r     <= is_cr_nxt;
      heat_r      <= heat_nxt;
      fan_r       <= fan_nxt;
      cfg_heat_r  <= cfg_heat_nxt;
      cfg_fan_r   <= cfg_fan_nxt;
      vld_r       <= vld_nxt;
      dv_r        <= rd_en;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload path
  always_ff @(posedge clk) begin
    didx_r <= raddr;
    rvld_r <= vld_r[raddr];
    ev_r   <= ev_nxt;
    pval_r <= pval_nxt;
    pok_r  <= pok_nxt;
    chan_r <= chan_nxt;
    if (load) begin
      out_ev_r   <= ev_r;
      out_pval_r <= pval_r;
      out_pok_r  <= pok_r;
      out_chan_r <= chan_r;
      out_lvl_r  <= heat_r;
      out_pat_r  <= heat_pattern(heat_r);
      out_duty_r <= fan_duty(fan_r);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_event_res      = out_ev_r;
  assign out_param_value    = out_pval_r;
  assign out_param_ok       = out_pok_r;
  assign out_channel_text   = out_chan_r;
  assign out_heater_level   = out_lvl_r;
  assign out_heater_pattern = out_pat_r;
  assign out_fan_duty       = out_duty_r;

endmodule

`default_nettype wire

### rtl/core/schfc_checker.sv
// port-level checker for the command line decoder, bound to the top level
// depends on schfc_pkg and serial_command_line_heater_fan_control_assert.svh
`default_nettype none

`include "serial_command_line_heater_fan_control_assert.svh"

module schfc_checker import schfc_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_event_res,
  input logic [6:0]  out_param_value,
  input logic        out_param_ok,
  input logic [31:0] out_channel_text,
  input logic [4:0]  out_heater_level,
  input logic [23:0] out_heater_pattern,
  input logic [9:0]  out_fan_duty
);

  // a stalled result keeps its settings fields
  `SCHFC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_event_res) && $stable(out_heater_pattern) && $stable(out_fan_duty), "stalled result changed")

  // only fan and heater lines carry a parameter
  `SCHFC_ASSERT_NOW(a_param_clear, out_valid && out_event_res != EV_FAN && out_event_res != EV_HEAT, !out_param_ok && out_param_value == 7'd0, "parameter on a line without one")

  // only channel lines carry channel text
  `SCHFC_ASSERT_NOW(a_chan_clear, out_valid && out_event_res != EV_CHAN, out_channel_text == 32'h0, "channel text on a non-channel line")

  // an accepted parameter is within range
  `SCHFC_ASSERT_NOW(a_param_range, out_valid && out_param_ok, out_param_value <= 7'(PARAM_MAX), "accepted parameter above limit")

  // heater level stays saturated
  `SCHFC_ASSERT_NOW(a_heat_cap, out_valid, out_heater_level <= HEAT_MAX, "heater level above maximum")

endmodule

bind serial_command_line_heater_fan_control schfc_checker u_schfc_checker (.*);

`default_nettype wire
